// ===== rtl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the slip torque limiter
// breakpoint and gain tables, datapath widths, config register codes
// ----------------------------------------------------------------------------
package stl_pkg;

  // table geometry
  localparam int SPEED_POINTS = 5;
  localparam int SLIP_POINTS  = 9;
  localparam int SPD_IW       = $clog2(SPEED_POINTS);
  localparam int SLP_IW       = $clog2(SLIP_POINTS);

  // datapath widths, set by the table contents
  localparam int SPD_W  = 12;  // clamped speed, at most 2560
  localparam int SLP_W  = 14;  // clamped slip, at most 16220
  localparam int DV_W   = 10;  // speed offset and span, at most 640
  localparam int DS_W   = 12;  // slip offset and span, at most 3277
  localparam int GAIN_W = 16;
  localparam int BL_W   = 26;  // gain blended along speed
  localparam int DEN_W  = 22;  // speed span times slip span
  localparam int NUM_W  = 38;  // full bilinear numerator
  localparam int QUO_W  = 16;  // biased gain quotient
  localparam int DVS_W  = DEN_W + 1;
  localparam int DIVN_W = DVS_W + QUO_W;
  localparam int ERR_W  = 17;
  localparam int PROD_W = 34;
  localparam int RED_SHIFT = 14;
  localparam int TQ_W   = 15;

  // pipeline depth
  localparam int INTERP_STAGES = 5;
  localparam int LIMIT_STAGES  = 3;
  localparam int LATENCY       = INTERP_STAGES + QUO_W + LIMIT_STAGES;

  // gain is biased positive for the unsigned divider
  localparam logic signed [QUO_W:0] GAIN_BIAS = 17'sd32768;
  localparam logic signed [PROD_W-1:0] RND_HALF = 34'sd8192;

  // configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIP_TARGET  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_LIMIT = 1'b1;
  localparam logic [15:0]     SLIP_TARGET_RST  = 16'd1311;
  localparam logic [TQ_W-1:0] TORQUE_LIMIT_RST = 15'd7450;

  // breakpoints, speed Q8.8 and slip Q2.14
  localparam logic [SPD_W-1:0] SPEED_BP [SPEED_POINTS] =
    '{12'd26, 12'd640, 12'd1280, 12'd1920, 12'd2560};
  localparam logic [SLP_W-1:0] SLIP_BP [SLIP_POINTS] =
    '{14'd1638, 14'd2130, 14'd2458, 14'd3277, 14'd4096,
      14'd6554, 14'd9830, 14'd13107, 14'd16220};

  // proportional gain, Q8.8, rows by speed
  localparam logic signed [GAIN_W-1:0] GAIN_TAB [SPEED_POINTS][SLIP_POINTS] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      -16'sd7001, -16'sd4098},
    '{-16'sd3267, -16'sd3425, -16'sd3536, -16'sd3928, -16'sd5211,
      -16'sd7219, -16'sd8205, -16'sd8849, 16'sd0},
    '{-16'sd5875, -16'sd6323, -16'sd6764, -16'sd8390, -16'sd9505,
      -16'sd12119, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd7368, -16'sd7635, -16'sd8228, -16'sd9691, -16'sd10780,
      -16'sd14095, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd10131, -16'sd12720, -16'sd15361, -16'sd19816, -16'sd22394,
      16'sd0, 16'sd0, 16'sd0, 16'sd0}
  };

  // data that rides along with a request
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [15:0]      req;
  } side_t;

  // divider stage payload
  typedef struct packed {
    logic [DVS_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [DVS_W-1:0] dvs;
    side_t            side;
  } div_t;

endpackage

// ===== rtl/stl_interp.sv =====
// ----------------------------------------------------------------------------
// stl_interp: clamp, segment search and bilinear blend
// five stages ending in the biased dividend for the divider chain
// ----------------------------------------------------------------------------
module stl_interp (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [15:0]        vehicle_speed,
  input  logic signed [15:0] slip_ratio,
  input  logic signed [15:0] requested_torque,
  input  logic signed [15:0] slip_target,
  output logic               out_vld,
  output stl_pkg::div_t      dout
);
  import stl_pkg::*;

  // stage 1
  logic              vld1;
  logic [SPD_W-1:0]  spd1;
  logic [SLP_W-1:0]  slp1;
  logic [SPD_IW-1:0] i1;
  logic [SLP_IW-1:0] j1;
  side_t             side1;
  // stage 2
  logic                     vld2;
  logic signed [GAIN_W-1:0] k00, k10, k01, k11;
  logic [DV_W-1:0]          dv2, svmdv2, sv2;
  logic [DS_W-1:0]          ds2, ssmds2, ss2;
  side_t                    side2;
  // stage 3
  logic                   vld3;
  logic signed [BL_W-1:0] bla, blb;
  logic [DS_W-1:0]        ds3, ssmds3;
  logic [DEN_W-1:0]       den3;
  side_t                  side3;
  // stage 4
  logic                    vld4;
  logic signed [NUM_W-1:0] num4;
  logic [DEN_W-1:0]        den4;
  side_t                   side4;

  logic [SPD_W-1:0]  spd_c;
  logic [SLP_W-1:0]  slp_c;
  logic [SPD_IW-1:0] seg_i, i_hi;
  logic [SLP_IW-1:0] seg_j, j_hi;
  logic signed [BL_W-1:0]   bla_c, blb_c;
  logic signed [NUM_W-1:0]  num_c;
  logic signed [DIVN_W:0]   dvd_c;

  // clamp and segment search
  always_comb begin
    if (vehicle_speed < {{(16-SPD_W){1'b0}}, SPEED_BP[0]}) begin
      spd_c = SPEED_BP[0];
    end else if (vehicle_speed > {{(16-SPD_W){1'b0}}, SPEED_BP[SPEED_POINTS-1]}) begin
      spd_c = SPEED_BP[SPEED_POINTS-1];
    end else begin
      spd_c = vehicle_speed[SPD_W-1:0];
    end
    if (slip_ratio < $signed({{(16-SLP_W){1'b0}}, SLIP_BP[0]})) begin
      slp_c = SLIP_BP[0];
    end else if (slip_ratio > $signed({{(16-SLP_W){1'b0}}, SLIP_BP[SLIP_POINTS-1]})) begin
      slp_c = SLIP_BP[SLIP_POINTS-1];
    end else begin
      slp_c = slip_ratio[SLP_W-1:0];
    end
    seg_i = '0;
    for (int k = 1; k <= SPEED_POINTS - 2; k++) begin
      if (spd_c >= SPEED_BP[k]) seg_i = SPD_IW'(k);
    end
    seg_j = '0;
    for (int k = 1; k <= SLIP_POINTS - 2; k++) begin
      if (slp_c >= SLIP_BP[k]) seg_j = SLP_IW'(k);
    end
  end

  assign i_hi = i1 + 1'b1;
  assign j_hi = j1 + 1'b1;

  // blend along speed, then along slip
  assign bla_c = k00 * $signed({1'b0, svmdv2}) + k10 * $signed({1'b0, dv2});
  assign blb_c = k01 * $signed({1'b0, svmdv2}) + k11 * $signed({1'b0, dv2});
  assign num_c = bla * $signed({1'b0, ssmds3}) + blb * $signed({1'b0, ds3});

  // 2*num + den, biased by 2*den*32768 so the quotient is never negative
  assign dvd_c = (num4 <<< 1) + $signed({1'b0, den4})
               + $signed({1'b0, den4, {QUO_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      vld2    <= vld1;
      vld3    <= vld2;
      vld4    <= vld3;
      out_vld <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    spd1      <= spd_c;
    slp1      <= slp_c;
    i1        <= seg_i;
    j1        <= seg_j;
    side1.err <= {slip_target[15], slip_target} - {slip_ratio[15], slip_ratio};
    side1.req <= requested_torque;

    k00    <= GAIN_TAB[i1][j1];
    k10    <= GAIN_TAB[i_hi][j1];
    k01    <= GAIN_TAB[i1][j_hi];
    k11    <= GAIN_TAB[i_hi][j_hi];
    sv2    <= DV_W'(SPEED_BP[i_hi] - SPEED_BP[i1]);
    dv2    <= DV_W'(spd1 - SPEED_BP[i1]);
    svmdv2 <= DV_W'(SPEED_BP[i_hi] - spd1);
    ss2    <= DS_W'(SLIP_BP[j_hi] - SLIP_BP[j1]);
    ds2    <= DS_W'(slp1 - SLIP_BP[j1]);
    ssmds2 <= DS_W'(SLIP_BP[j_hi] - slp1);
    side2  <= side1;

    bla    <= bla_c;
    blb    <= blb_c;
    ds3    <= ds2;
    ssmds3 <= ssmds2;
    den3   <= DEN_W'(sv2 * ss2);
    side3  <= side2;

    num4  <= num_c;
    den4  <= den3;
    side4 <= side3;

    dout.rem  <= dvd_c[DIVN_W-1:QUO_W];
    dout.quo  <= dvd_c[QUO_W-1:0];
    dout.dvs  <= {den4, 1'b0};
    dout.side <= side4;
  end

endmodule

// ===== rtl/stl_div_step.sv =====
// ----------------------------------------------------------------------------
// stl_div_step: one restoring division step
// shifts one dividend bit into the partial remainder, emits one quotient bit
// ----------------------------------------------------------------------------
module stl_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  stl_pkg::div_t din,
  output logic          out_vld,
  output stl_pkg::div_t dout
);
  import stl_pkg::*;

  logic [DVS_W:0]   trial;
  logic [DVS_W+1:0] diff;
  logic             ge;

  assign trial = {din.rem, din.quo[QUO_W-1]};
  assign diff  = {1'b0, trial} - {2'b0, din.dvs};
  assign ge    = !diff[DVS_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    dout.rem  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    dout.quo  <= {din.quo[QUO_W-2:0], ge};
    dout.dvs  <= din.dvs;
    dout.side <= din.side;
  end

endmodule

// ===== rtl/stl_limit.sv =====
// ----------------------------------------------------------------------------
// stl_limit: torque reduction and output clamp
// gain times slip error, rounding, clamps and limit flags
// ----------------------------------------------------------------------------
module stl_limit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_vld,
  input  logic [stl_pkg::QUO_W-1:0] quo,
  input  stl_pkg::side_t           side,
  input  logic [stl_pkg::TQ_W-1:0] torque_limit,
  output logic                     done,
  output logic [stl_pkg::TQ_W-1:0] limited_torque,
  output logic [stl_pkg::TQ_W-1:0] torque_reduction,
  output logic                     hit_limit,
  output logic                     hit_zero
);
  import stl_pkg::*;

  localparam int RR_W = PROD_W - RED_SHIFT;

  logic                     vld_a, vld_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [15:0]       req_a, req_b;
  logic [TQ_W-1:0]          red_b;

  logic signed [ERR_W-1:0]  gain_c;
  logic signed [PROD_W-1:0] prod_c, rnd_c;
  logic signed [RR_W-1:0]   rr_c;
  logic [TQ_W-1:0]          red_c;
  logic signed [16:0]       diff_c, tl_s;

  assign gain_c = $signed({1'b0, quo}) - GAIN_BIAS;
  assign prod_c = gain_c * side.err;

  // round Q22 product to Q8.8, ties up, then clamp to [0, limit]
  assign rnd_c = prod + RND_HALF;
  assign rr_c  = rnd_c[PROD_W-1:RED_SHIFT];
  always_comb begin
    if (rr_c < 0) begin
      red_c = '0;
    end else if (rr_c > $signed({{(RR_W-TQ_W){1'b0}}, torque_limit})) begin
      red_c = torque_limit;
    end else begin
      red_c = rr_c[TQ_W-1:0];
    end
  end

  assign diff_c = {req_b[15], req_b} - {2'b0, red_b};
  assign tl_s   = $signed({2'b0, torque_limit});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      done  <= 1'b0;
    end else begin
      vld_a <= in_vld;
      vld_b <= vld_a;
      done  <= vld_b;
    end
  end

  always_ff @(posedge clk) begin
    prod  <= prod_c;
    req_a <= side.req;
    red_b <= red_c;
    req_b <= req_a;
    torque_reduction <= red_b;
    if (diff_c > tl_s) begin
      limited_torque <= torque_limit;
      hit_limit      <= 1'b1;
      hit_zero       <= 1'b0;
    end else if (diff_c < 0) begin
      limited_torque <= '0;
      hit_limit      <= 1'b0;
      hit_zero       <= 1'b1;
    end else begin
      limited_torque <= diff_c[TQ_W-1:0];
      hit_limit      <= 1'b0;
      hit_zero       <= 1'b0;
    end
  end

endmodule

// ===== rtl/slip_torque_limiter_top.sv =====
// ----------------------------------------------------------------------------
// slip_torque_limiter_top: gain-scheduled traction control torque limiter
// bilinear gain lookup over speed and slip, proportional torque reduction
// ----------------------------------------------------------------------------
// Takes one request per clock: pulse start with vehicle_speed, slip_ratio and
// requested_torque; busy is high only during reset. Every request gives exactly
// one result, marked by a one-cycle done pulse, in request order; there is no
// backpressure, so capture the result in the done cycle. The pipeline holds
// five stages of clamp, segment search, table lookup and bilinear blend,
// sixteen restoring divider steps (one quotient bit each) for the division
// by the cell area, and three stages of gain times slip error, rounding and
// clamping. Write slip_target (index 0) and torque_limit (index 1) through
// cfg_we only while no request is in flight; torque_limit is read by the last
// stages directly.
module slip_torque_limiter_top (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  logic [15:0]                  vehicle_speed,
  input  logic signed [15:0]           slip_ratio,
  input  logic signed [15:0]           requested_torque,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [stl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]                  cfg_data,
  // result channel
  output logic                         done,
  output logic [stl_pkg::TQ_W-1:0]     limited_torque,
  output logic [stl_pkg::TQ_W-1:0]     torque_reduction,
  output logic                         hit_limit,
  output logic                         hit_zero
);
  import stl_pkg::*;

  // configuration registers
  logic signed [15:0] slip_target;
  logic [TQ_W-1:0]    torque_limit;

  // divider chain taps, entry 0 is the interpolator output
  logic  div_vld [QUO_W+1];
  div_t  div_bus [QUO_W+1];

  // only reset holds requests off
  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      slip_target  <= SLIP_TARGET_RST;
      torque_limit <= TORQUE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SLIP_TARGET:  slip_target  <= cfg_data;
        CFG_TORQUE_LIMIT: torque_limit <= cfg_data[TQ_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp, segment search and blend: yields the biased dividend
  stl_interp u_interp (
    .clk              (clk),
    .rst              (rst),
    .in_vld           (start && !busy),
    .vehicle_speed    (vehicle_speed),
    .slip_ratio       (slip_ratio),
    .requested_torque (requested_torque),
    .slip_target      (slip_target),
    .out_vld          (div_vld[0]),
    .dout             (div_bus[0])
  );

  // one quotient bit per stage, msb first
  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    stl_div_step u_step (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (div_vld[g]),
      .din     (div_bus[g]),
      .out_vld (div_vld[g+1]),
      .dout    (div_bus[g+1])
    );
  end

  // reduction, output clamp and flags
  stl_limit u_limit (
    .clk              (clk),
    .rst              (rst),
    .in_vld           (div_vld[QUO_W]),
    .quo              (div_bus[QUO_W].quo),
    .side             (div_bus[QUO_W].side),
    .torque_limit     (torque_limit),
    .done             (done),
    .limited_torque   (limited_torque),
    .torque_reduction (torque_reduction),
    .hit_limit        (hit_limit),
    .hit_zero         (hit_zero)
  );

endmodule

// ===== rtl/stl_checker.sv =====
// ----------------------------------------------------------------------------
// stl_checker: port-level checks of the slip torque limiter
// result timing, clamp flags and limit against a shadow of the config
// ----------------------------------------------------------------------------
module stl_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          cfg_we,
  input  logic [stl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]                   cfg_data,
  input  logic                          done,
  input  logic [stl_pkg::TQ_W-1:0]      limited_torque,
  input  logic [stl_pkg::TQ_W-1:0]      torque_reduction,
  input  logic                          hit_limit,
  input  logic                          hit_zero
);
  import stl_pkg::*;

  logic [TQ_W-1:0] tl_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      tl_shadow <= TORQUE_LIMIT_RST;
    end else if (cfg_we && cfg_idx == CFG_TORQUE_LIMIT) begin
      tl_shadow <= cfg_data[TQ_W-1:0];
    end
  end

  // every result traces back to an accepted request
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit_limit && hit_zero))
    else $error("both clamp flags set");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && hit_zero) |-> (limited_torque == '0))
    else $error("zero clamp with nonzero torque");

  a_limit: assert property (@(posedge clk) disable iff (rst)
    done |-> (limited_torque <= tl_shadow && torque_reduction <= tl_shadow &&
              (!hit_limit || limited_torque == tl_shadow)))
    else $error("output beyond torque limit");

endmodule

bind slip_torque_limiter_top stl_checker u_stl_checker (.*);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the slip torque limiter
// drives requests through the command port, predicts every result from the
// scheduled gain and the current target and limit, and compares each result
// in order while the sender gap profile and the register settings change
// ----------------------------------------------------------------------------
module tb;

  // number of cycles after which the run is declared hung
  localparam int RUN_LIMIT = 300000;
  localparam int NSPD = stl_pkg::SPEED_POINTS;
  localparam int NSLP = stl_pkg::SLIP_POINTS;
  localparam int SEGMENTS = 7;
  localparam int SEG_REQS = 200;

  // schedule breakpoints and gain grid, speed and gain Q8.8, slip Q2.14
  localparam int SPD_KNOT [NSPD] = '{26, 640, 1280, 1920, 2560};
  localparam int SLP_KNOT [NSLP] = '{1638, 2130, 2458, 3277, 4096, 6554, 9830,
                                     13107, 16220};
  localparam int KP_GRID [NSPD][NSLP] = '{
    '{0, 0, 0, 0, 0, 0, 0, -7001, -4098},
    '{-3267, -3425, -3536, -3928, -5211, -7219, -8205, -8849, 0},
    '{-5875, -6323, -6764, -8390, -9505, -12119, 0, 0, 0},
    '{-7368, -7635, -8228, -9691, -10780, -14095, 0, 0, 0},
    '{-10131, -12720, -15361, -19816, -22394, 0, 0, 0, 0}
  };

  // one torque command as the block should report it
  typedef struct {
    logic [14:0] lim;
    logic [14:0] red;
    logic        at_lim;
    logic        at_zero;
  } torque_cmd_t;

  class torque_scoreboard;
    longint slip_tgt;
    longint tq_lim;
    torque_cmd_t pending[$];
    int requests;
    int results;
    int errors;

    function new();
      slip_tgt = 1311;
      tq_lim   = 7450;
      requests = 0;
      results  = 0;
      errors   = 0;
    endfunction

    function void write_reg(logic [stl_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        stl_pkg::CFG_SLIP_TARGET:  slip_tgt = longint'($signed(val));
        stl_pkg::CFG_TORQUE_LIMIT: tq_lim   = longint'(val[14:0]);
        default: ;
      endcase
    endfunction

    // floor division, then nearest with ties upward, divisor positive
    function longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
    endfunction

    function longint round_quot(longint n, longint d);
      return floor_quot(2 * n + d, 2 * d);
    endfunction

    // bilinear blend of the gain grid at the clamped operating point
    function longint sched_gain(longint v, longint s);
      int i;
      int j;
      longint sv, ss, dv, ds, num;
      if (v < SPD_KNOT[0]) v = SPD_KNOT[0];
      if (v > SPD_KNOT[NSPD-1]) v = SPD_KNOT[NSPD-1];
      if (s < SLP_KNOT[0]) s = SLP_KNOT[0];
      if (s > SLP_KNOT[NSLP-1]) s = SLP_KNOT[NSLP-1];
      i = 0;
      for (int k = 1; k <= NSPD - 2; k++) if (v >= SPD_KNOT[k]) i = k;
      j = 0;
      for (int k = 1; k <= NSLP - 2; k++) if (s >= SLP_KNOT[k]) j = k;
      sv = SPD_KNOT[i+1] - SPD_KNOT[i];
      ss = SLP_KNOT[j+1] - SLP_KNOT[j];
      dv = v - SPD_KNOT[i];
      ds = s - SLP_KNOT[j];
      num = (KP_GRID[i][j] * (sv - dv) + KP_GRID[i+1][j] * dv) * (ss - ds)
          + (KP_GRID[i][j+1] * (sv - dv) + KP_GRID[i+1][j+1] * dv) * ds;
      return round_quot(num, sv * ss);
    endfunction

    function torque_cmd_t predict(logic [15:0] spd, logic signed [15:0] slp,
                                  logic signed [15:0] trq);
      longint g, err, red, diff;
      torque_cmd_t c;
      g   = sched_gain(longint'(spd), longint'(slp));
      // error from the raw slip, not the clamped one
      err = slip_tgt - longint'(slp);
      red = round_quot(g * err, 16384);
      if (red < 0) red = 0;
      if (red > tq_lim) red = tq_lim;
      diff = longint'(trq) - red;
      c.at_lim  = 1'b0;
      c.at_zero = 1'b0;
      if (diff > tq_lim) begin
        diff = tq_lim;
        c.at_lim = 1'b1;
      end else if (diff < 0) begin
        diff = 0;
        c.at_zero = 1'b1;
      end
      c.lim = 15'(diff);
      c.red = 15'(red);
      return c;
    endfunction

    function void note_request(logic [15:0] spd, logic signed [15:0] slp,
                               logic signed [15:0] trq);
      pending.push_back(predict(spd, slp, trq));
      requests++;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_result(logic [14:0] lim, logic [14:0] red, logic hl, logic hz);
      torque_cmd_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %0d/%0d with no request outstanding", lim, red));
        return;
      end
      want = pending.pop_front();
      results++;
      if (lim !== want.lim)
        report($sformatf("result %0d limited_torque %0d, want %0d", results, lim, want.lim));
      if (red !== want.red)
        report($sformatf("result %0d torque_reduction %0d, want %0d", results, red,
                         want.red));
      if (hl !== want.at_lim)
        report($sformatf("result %0d hit_limit %b, want %b", results, hl, want.at_lim));
      if (hz !== want.at_zero)
        report($sformatf("result %0d hit_zero %b, want %b", results, hz, want.at_zero));
    endtask
  endclass

  // clock, reset and block inputs, all known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [15:0] vehicle_speed = '0;
  logic signed [15:0] slip_ratio = '0;
  logic signed [15:0] requested_torque = '0;
  logic cfg_we = 1'b0;
  logic [stl_pkg::CFG_IDX_W-1:0] cfg_idx = stl_pkg::CFG_SLIP_TARGET;
  logic [15:0] cfg_data = '0;

  logic busy;
  logic done;
  logic [stl_pkg::TQ_W-1:0] limited_torque;
  logic [stl_pkg::TQ_W-1:0] torque_reduction;
  logic hit_limit;
  logic hit_zero;

  int cycles = 0;

  torque_scoreboard sb = new();

  slip_torque_limiter_top dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .vehicle_speed    (vehicle_speed),
    .slip_ratio       (slip_ratio),
    .requested_torque (requested_torque),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_data         (cfg_data),
    .done             (done),
    .limited_torque   (limited_torque),
    .torque_reduction (torque_reduction),
    .hit_limit        (hit_limit),
    .hit_zero         (hit_zero)
  );

  always #5 clk = ~clk;

  // results cannot be held off, so take each one in its done cycle
  always @(posedge clk) begin
    if (!rst && done === 1'b1)
      sb.check_result(limited_torque, torque_reduction, hit_limit, hit_zero);
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // present one request and hold it until the block takes it
  task automatic send(input logic [15:0] spd, input logic signed [15:0] slp,
                      input logic signed [15:0] trq);
    start            <= 1'b1;
    vehicle_speed    <= spd;
    slip_ratio       <= slp;
    requested_torque <= trq;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_request(spd, slp, trq);
  endtask

  // sender idles each cycle with the given percent chance
  task automatic idle_gap(input int pct);
    while (pct > 0 && $urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop sending until every outstanding request has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // both registers, back to back, block idle
  task automatic program_regs(input logic [15:0] st, input logic [15:0] tl);
    cfg_we   <= 1'b1;
    cfg_idx  <= stl_pkg::CFG_SLIP_TARGET;
    cfg_data <= st;
    @(posedge clk);
    sb.write_reg(stl_pkg::CFG_SLIP_TARGET, st);
    cfg_idx  <= stl_pkg::CFG_TORQUE_LIMIT;
    cfg_data <= tl;
    @(posedge clk);
    sb.write_reg(stl_pkg::CFG_TORQUE_LIMIT, tl);
    cfg_we   <= 1'b0;
  endtask

  // corners of the fields, the clamp edges and the output clamp cases
  task automatic directed_requests();
    int r;
    torque_cmd_t probe;
    send(16'd0, 16'sd0, 16'sd0);
    send(16'd26, 16'sd1638, 16'sd7450);
    send(16'd640, 16'sd2130, 16'sd1000);
    // deep negative demand clamps to zero
    send(16'd1280, 16'sd2458, -16'sd32768);
    // huge demand clamps to the limit
    send(16'd1920, 16'sd3277, 16'sd32767);
    send(16'd2560, 16'sd16220, 16'sd5000);
    // one past the top breakpoints
    send(16'd2561, 16'sd16221, 16'sd5000);
    send(16'd65535, 16'sd32767, 16'sd100);
    // raw slip far above the clamp gives a reduction above the limit
    send(16'd0, 16'sd32767, 16'sd8000);
    send(16'd65535, -16'sd32768, 16'sd32767);
    // slip on target, no error
    send(16'd1000, 16'sd1311, 16'sd2000);
    send(16'd700, 16'sd5000, 16'sd0);
    // demand equal to the reduction lands exactly on zero, not a clamp
    probe = sb.predict(16'd1500, 16'sd4000, 16'sd0);
    r = int'(probe.red);
    send(16'd1500, 16'sd4000, 16'(r));
    // exactly at the limit, then one over, then one under zero
    send(16'd1500, 16'sd4000, 16'(r + 7450));
    send(16'd1500, 16'sd4000, 16'(r + 7451));
    send(16'd1500, 16'sd4000, 16'(r - 1));
    send(16'd2559, 16'sd16219, 16'sd12345);
    send(16'd27, 16'sd1639, -16'sd1);
    send(16'd32768, -16'sd1, 16'sd7450);
    send(16'd1279, 16'sd9829, 16'sd7000);
    send(16'd65535, 16'sd16384, 16'sd20000);
  endtask

  // mostly operating points inside the schedule, some near the knots,
  // some raw 16-bit noise
  task automatic rand_request();
    int k;
    int spd;
    int slp;
    int trq;
    k = $urandom_range(0, 9);
    if (k < 6) spd = $urandom_range(0, 2700);
    else if (k < 8) spd = SPD_KNOT[$urandom_range(0, NSPD-1)] + $urandom_range(0, 4) - 2;
    else spd = $urandom_range(0, 65535);
    k = $urandom_range(0, 9);
    if (k < 5) slp = $urandom_range(1400, 16500);
    else if (k < 6) slp = $urandom_range(0, 1400);
    else if (k < 8) slp = SLP_KNOT[$urandom_range(0, NSLP-1)] + $urandom_range(0, 4) - 2;
    else slp = $urandom_range(0, 65535);
    k = $urandom_range(0, 9);
    if (k < 4) trq = $urandom_range(0, 65535);
    else trq = $urandom_range(0, int'(sb.tq_lim) + 600) - 300;
    send(16'(spd), 16'(slp), 16'(trq));
  endtask

  initial begin
    int idle_pct;
    logic [15:0] st;
    logic [15:0] tl;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of target and limit first
    directed_requests();
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin st = 16'h7fff; tl = 16'h7fff; end
        1: begin st = 16'h8000; tl = 16'h0000; end
        2: begin st = 16'h0000; tl = 16'h0001; end
        4: begin st = 16'd1311; tl = 16'd7450; end
        6: begin
          st = 16'($urandom_range(0, 16384));
          tl = 16'($urandom_range(1000, 12000));
        end
        default: begin
          st = 16'($urandom_range(0, 65535));
          tl = 16'($urandom_range(0, 32767));
        end
      endcase
      // the unused top bit of the limit write must be dropped
      tl[15] = 1'($urandom_range(0, 1));
      program_regs(st, tl);

      // sender gaps: light, then heavy, then back to back
      idle_pct = (seg < 2) ? 9 : (seg < 4) ? 63 : 0;
      for (int n = 0; n < SEG_REQS; n++) begin
        rand_request();
        if (seg == 3 && n == SEG_REQS / 2) wait_drained();
        else idle_gap(idle_pct);
      end
      wait_drained();
    end

    // catch any stray result after the last one
    repeat (stl_pkg::LATENCY + 16) @(posedge clk);

    $display("covered %0d requests over %0d target and limit settings, sender gaps light,",
             sb.requests, SEGMENTS + 1);
    $display("heavy and none; %0d results checked, %0d mismatches", sb.results, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
